// ----- sv/sha256_pkg.sv -----
// SHA-256 constants and round functions.
package sha256_pkg;

   localparam logic [31:0] HASH_INIT [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

endpackage

// ----- sv/sha256_message_digest.sv -----
// SHA-256 byte-stream hasher: packing, padding, compression and digest output.
// A byte that does not fill a block is taken while idle; after a byte that fills a
// block, input waits for a start step, 16 plain and 48 expanding rounds and a chain add.
// A final item pads one byte per cycle outside compression (9 to 72 bytes), with one or two compressions in
// total, then shows 8 digest transactions, one per cycle while rsp_tready is high.
// One item is worked on at a time. Reset (synchronous, active high) restores the initial hash.
module sha256_message_digest (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] has_byte
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_PAD, ST_RD0, ST_RD1, ST_RD2, ST_SCHED, ST_ROUND, ST_ADD, ST_OUT
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] sched_mem [16];
   logic [31:0] rd_data_ff;
   logic [3:0]  rd_addr;
   logic        wr_en;
   logic [3:0]  wr_addr;
   logic [31:0] wr_data;

   logic [31:0] chain_ff [8], chain_in [8];
   logic [31:0] wv_ff [8], wv_in [8];
   logic [31:0] asm_ff, asm_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] plen_ff, plen_in;
   logic        final_ff, final_in;
   logic        mark_ff, mark_in;
   logic        lenph_ff, lenph_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [31:0] x15_ff, x15_in, x2_ff, x2_in, x7_ff, x7_in;
   logic [31:0] wt_ff, wt_in;
   logic [2:0]  oidx_ff, oidx_in;

   logic [7:0]  pbyte;
   logic        push;
   logic [5:0]  npos;
   logic [31:0] nasm;
   logic [31:0] wt, t1, t2;
   logic        expand;
   logic        len_now;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         sched_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= sched_mem[rd_addr];
   end

   // Length bytes start once the zeros after the pad byte reach byte 56 of a block.
   assign len_now = mark_ff && (lenph_ff || pos_ff == sha256_pkg::LEN_POS);

   // Padding byte sequence: 0x80, zeros up to byte 56, then big-endian length.
   always_comb begin
      if (!mark_ff) begin
         pbyte = sha256_pkg::PAD_BYTE;
      end else if (len_now) begin
         pbyte = plen_ff[63:56];
      end else begin
         pbyte = 8'h00;
      end
   end

   assign expand = (rnd_ff >= 6'd16);
   assign wt = expand ? (rd_data_ff + sha256_pkg::ssig0(x15_ff) + sha256_pkg::ssig1(x2_ff)
                         + x7_ff)
                      : rd_data_ff;
   assign t1 = wv_ff[7] + sha256_pkg::bsig1(wv_ff[4])
             + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
             + sha256_pkg::ROUND_K[rnd_ff] + wt_ff;
   assign t2 = sha256_pkg::bsig0(wv_ff[0])
             + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = chain_ff[oidx_ff];
   assign rsp_tuser  = oidx_ff;
   assign rsp_tlast  = (oidx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      chain_in = chain_ff;
      wv_in    = wv_ff;
      asm_in   = asm_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      plen_in  = plen_ff;
      final_in = final_ff;
      mark_in  = mark_ff;
      lenph_in = lenph_ff;
      rnd_in   = rnd_ff;
      x15_in   = x15_ff;
      x2_in    = x2_ff;
      x7_in    = x7_ff;
      wt_in    = wt_ff;
      oidx_in  = oidx_ff;
      rd_addr  = 4'd0;
      wr_en    = 1'b0;
      wr_addr  = pos_ff[5:2];
      wr_data  = 32'd0;
      push     = 1'b0;
      nasm     = {asm_ff[23:0], pbyte};
      npos     = pos_ff + 6'd1;

      unique case (state_ff)
         ST_IDLE: begin
            nasm = {asm_ff[23:0], req_tdata};
            if (req_tvalid) begin
               plen_in = len_ff + {60'd0, req_tuser, 3'd0};
               if (req_tuser) begin
                  push   = 1'b1;
                  len_in = len_ff + 64'd8;
               end
               if (req_tlast) begin
                  final_in = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            push    = 1'b1;
            mark_in = 1'b1;
            if (len_now) begin
               plen_in  = {plen_ff[55:0], 8'd0};
               lenph_in = 1'b1;
            end
         end
         ST_RD0: begin
            rd_addr = 4'd0;
            for (int i = 0; i < 8; i++) wv_in[i] = chain_ff[i];
            rnd_in   = 6'd0;
            state_in = ST_RD1;
         end
         // Fetch w[t-15], w[t-2], w[t-7], then w[t-16] for rounds past 15.
         ST_RD1: begin
            rd_addr  = rnd_ff[3:0] - 4'd15;
            state_in = expand ? ST_RD2 : ST_SCHED;
            if (!expand) rd_addr = rnd_ff[3:0];
         end
         ST_RD2: begin
            state_in = ST_RD2;
            unique case (oidx_ff)
               3'd0: begin
                  x15_in  = rd_data_ff;
                  rd_addr = rnd_ff[3:0] - 4'd2;
                  oidx_in = 3'd1;
               end
               3'd1: begin
                  x2_in   = rd_data_ff;
                  rd_addr = rnd_ff[3:0] - 4'd7;
                  oidx_in = 3'd2;
               end
               default: begin
                  x7_in    = rd_data_ff;
                  rd_addr  = rnd_ff[3:0];
                  oidx_in  = 3'd0;
                  state_in = ST_SCHED;
               end
            endcase
         end
         // Register the schedule word and write the expanded one back.
         ST_SCHED: begin
            wt_in    = wt;
            wr_en    = expand;
            wr_addr  = rnd_ff[3:0];
            wr_data  = wt;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            wv_in[7] = wv_ff[6];
            wv_in[6] = wv_ff[5];
            wv_in[5] = wv_ff[4];
            wv_in[4] = wv_ff[3] + t1;
            wv_in[3] = wv_ff[2];
            wv_in[2] = wv_ff[1];
            wv_in[1] = wv_ff[0];
            wv_in[0] = t1 + t2;
            rnd_in   = rnd_ff + 6'd1;
            state_in = (rnd_ff == 6'd63) ? ST_ADD : ST_RD1;
         end
         ST_ADD: begin
            for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + wv_ff[i];
            if (!final_ff) begin
               state_in = ST_IDLE;
            end else if (lenph_ff) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) chain_in[i] = sha256_pkg::HASH_INIT[i];
                  len_in   = 64'd0;
                  final_in = 1'b0;
                  mark_in  = 1'b0;
                  lenph_in = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (push) begin
         asm_in = nasm;
         pos_in = npos;
         if (npos[1:0] == 2'd0) begin
            wr_en   = 1'b1;
            wr_addr = pos_ff[5:2];
            wr_data = nasm;
            asm_in  = 32'd0;
         end
         if (npos == 6'd0) begin
            state_in = ST_RD0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 8; i++) begin
            chain_ff[i] <= sha256_pkg::HASH_INIT[i];
            wv_ff[i]    <= 32'd0;
         end
         asm_ff   <= 32'd0;
         pos_ff   <= 6'd0;
         len_ff   <= 64'd0;
         final_ff <= 1'b0;
         mark_ff  <= 1'b0;
         lenph_ff <= 1'b0;
         rnd_ff   <= 6'd0;
         oidx_ff  <= 3'd0;
      end else begin
         state_ff <= state_in;
         chain_ff <= chain_in;
         wv_ff    <= wv_in;
         asm_ff   <= asm_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         final_ff <= final_in;
         mark_ff  <= mark_in;
         lenph_ff <= lenph_in;
         rnd_ff   <= rnd_in;
         oidx_ff  <= oidx_in;
      end
      plen_ff <= plen_in;
      x15_ff  <= x15_in;
      x2_ff   <= x2_in;
      x7_ff   <= x7_in;
      wt_ff   <= wt_in;
   end

endmodule
